// File: rtl/core/wdcm_pkg.sv
// ----------------------------------------------------------------------------
// wdcm_pkg: shared types and constants of the window distinct count block
// Field widths, queue depth, count table entry layout and FSM states.
// ----------------------------------------------------------------------------
package wdcm_pkg;

  // Default sizes of the history line and of the symbol space.
  localparam int WINDOW_MAX_DEF  = 1024;
  localparam int SYMBOL_BITS_DEF = 10;

  // Widths fixed by the register and result fields.
  localparam int LEN_W = 11;
  localparam int CNT_W = 11;

  // Sequence tag kept next to each count table entry.
  localparam int EPOCH_W = 8;

  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IDX_WINDOW_LEN = 1'b0;

  // Classification of one item, made by the front.
  typedef struct packed {
    logic has_old;     // window already full: the oldest symbol departs
    logic first_full;  // this item completes the first full window
    logic last;        // final item of the sequence
  } wdcm_flags_t;

  // One count table entry: a count is valid only under the current tag.
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]   cnt;
  } wdcm_cnt_entry_t;

  // Back part sequencer.
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_CALC,
    B_WRITE_OLD
  } wdcm_back_state_t;

endpackage

// File: rtl/core/window_distinct_count_min_top.sv
// ----------------------------------------------------------------------------
// window_distinct_count_min_top: sliding window distinct count minimum
// The back takes each item through a read and an update step, adding a write
// step when a full window drops a symbol other than the arriving one, as the
// count table has one write port; no item is taken until the last is done.
// Reset: synchronous; a clearing pass of all 2**SYMBOL_BITS entries, with no
// item accepted, follows reset and every 256th sequence end or register write.
// ----------------------------------------------------------------------------
module window_distinct_count_min_top #(
  parameter int WINDOW_MAX  = wdcm_pkg::WINDOW_MAX_DEF,
  parameter int SYMBOL_BITS = wdcm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wdcm_pkg::ADDR_W-1:0]   paddr,
  input  logic [wdcm_pkg::DATA_W-1:0]   pwdata,
  output logic [wdcm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Item input.
  input  logic [SYMBOL_BITS-1:0]        symbol,
  input  logic                          last,
  input  logic                          in_valid,
  output logic                          in_stall,
  // Result output.
  output logic [wdcm_pkg::CNT_W-1:0]    min_distinct,
  output logic                          short_sequence,
  output logic                          out_valid,
  input  logic                          out_stall
);
  import wdcm_pkg::*;

  localparam int ENTRY_W = $bits(wdcm_flags_t) + 2 * SYMBOL_BITS;

  logic [LEN_W-1:0]   window_len;
  logic [LEN_W-1:0]   w_min1;
  logic [LEN_W-1:0]   weff;
  logic               cfg_hit;
  logic               cfg_clr;
  logic               clearing;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_head;

  // Register access.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_IDX_WINDOW_LEN);
  assign cfg_clr = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? DATA_W'(window_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_W'(1);
    end else if (cfg_clr) begin
      window_len <= pwdata[LEN_W-1:0];
    end
  end

  // Effective window: zero counts as one, large values saturate.
  always_comb begin
    w_min1 = (window_len == '0) ? LEN_W'(1) : window_len;
    if (32'(w_min1) > 32'(WINDOW_MAX)) begin
      weff = LEN_W'(WINDOW_MAX);
    end else begin
      weff = w_min1;
    end
  end

  wdcm_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .clr      (cfg_clr),
    .hold     (clearing),
    .weff     (weff),
    .symbol   (symbol),
    .last     (last),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  wdcm_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_clr),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  wdcm_back #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .clr            (cfg_clr),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .min_distinct   (min_distinct),
    .short_sequence (short_sequence),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule

// File: rtl/core/wdcm_queue.sv
// ----------------------------------------------------------------------------
// wdcm_queue: short item queue between front and back
// A small register FIFO; the head is visible while not empty.
// ----------------------------------------------------------------------------
module wdcm_queue #(
  parameter int DATA_W = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              empty
);
  import wdcm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("item pushed into a full queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("item popped from an empty queue");

  // The fill count tracks pushes and pops.
  a_count_step: assert property (@(posedge clk) disable iff (rst || clr)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// File: rtl/core/wdcm_front.sv
// ----------------------------------------------------------------------------
// wdcm_front: item intake and classification
// Keeps the fill count and the symbol history line, fetches the departing
// symbol and hands each classified item to the queue.
// ----------------------------------------------------------------------------
module wdcm_front #(
  parameter int WINDOW_MAX  = wdcm_pkg::WINDOW_MAX_DEF,
  parameter int SYMBOL_BITS = wdcm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         hold,
  input  logic [wdcm_pkg::LEN_W-1:0]   weff,
  input  logic [SYMBOL_BITS-1:0]       symbol,
  input  logic                         last,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [$bits(wdcm_pkg::wdcm_flags_t)+2*SYMBOL_BITS-1:0] q_data
);
  import wdcm_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int AW    = PTR_W + 1;

  logic [SYMBOL_BITS-1:0] hist [WINDOW_MAX];
  logic [SYMBOL_BITS-1:0] hist_rdata;

  logic [LEN_W-1:0]       fill;
  logic [PTR_W-1:0]       wr_pos;
  logic                   s1_valid;
  logic [SYMBOL_BITS-1:0] s1_sym;
  wdcm_flags_t            s1_flags;

  logic                   accept;
  logic                   has_old;
  logic                   first_full;
  logic [LEN_W-1:0]       fill_inc;
  logic [AW-1:0]          wp_ext;
  logic [AW-1:0]          wl_ext;
  logic [AW-1:0]          old_ext;
  logic [PTR_W-1:0]       old_pos;
  logic [PTR_W-1:0]       wr_pos_inc;

  // Handshake: the holding stage frees up as soon as it hands off.
  assign q_push   = s1_valid && !q_full;
  assign in_stall = hold || (s1_valid && !q_push);
  assign accept   = in_valid && !in_stall;
  assign q_data   = {s1_flags, hist_rdata, s1_sym};

  // Classify the item and locate the departing symbol.
  always_comb begin
    has_old    = (fill >= weff);
    fill_inc   = fill + 1'b1;
    first_full = !has_old && (fill_inc == weff);
    wp_ext     = AW'(wr_pos);
    wl_ext     = AW'(weff);
    if (wp_ext >= wl_ext) begin
      old_ext = wp_ext - wl_ext;
    end else begin
      old_ext = wp_ext + AW'(WINDOW_MAX) - wl_ext;
    end
    old_pos    = old_ext[PTR_W-1:0];
    wr_pos_inc = (wr_pos == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_pos + 1'b1;
  end

  // Control state: fill count, write position, holding stage.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      s1_valid <= 1'b0;
      fill     <= '0;
      wr_pos   <= '0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      fill     <= last ? '0 : (has_old ? fill : fill_inc);
      wr_pos   <= last ? '0 : wr_pos_inc;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  // Holding stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sym           <= symbol;
      s1_flags.has_old    <= has_old;
      s1_flags.first_full <= first_full;
      s1_flags.last       <= last;
    end
  end

  // History line: the departing slot is read before the new symbol lands.
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_rdata     <= hist[old_pos];
      hist[wr_pos]   <= symbol;
    end
  end

endmodule

// File: rtl/core/wdcm_back.sv
// ----------------------------------------------------------------------------
// wdcm_back: count table update and result delivery
// Read-modify-writes the occurrence count table for the arriving and the
// departing symbol, tracks distinct and minimum counts, and emits results.
// ----------------------------------------------------------------------------
module wdcm_back #(
  parameter int SYMBOL_BITS = wdcm_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         q_empty,
  input  logic [$bits(wdcm_pkg::wdcm_flags_t)+2*SYMBOL_BITS-1:0] q_head,
  output logic                         q_pop,
  output logic                         clearing,
  output logic [wdcm_pkg::CNT_W-1:0]   min_distinct,
  output logic                         short_sequence,
  output logic                         out_valid,
  input  logic                         out_stall
);
  import wdcm_pkg::*;

  localparam int SW      = SYMBOL_BITS;
  localparam int SYM_CNT = 2 ** SYMBOL_BITS;
  localparam int FLAGS_W = $bits(wdcm_flags_t);

  wdcm_cnt_entry_t cnt_mem [SYM_CNT];
  wdcm_cnt_entry_t rd_a;
  wdcm_cnt_entry_t rd_b;

  wdcm_back_state_t state;
  wdcm_back_state_t state_next;

  logic [SW-1:0]      head_sym;
  logic [SW-1:0]      head_old;
  wdcm_flags_t        head_flags;

  logic [SW-1:0]      e_sym;
  logic [SW-1:0]      e_old;
  wdcm_flags_t        e_flags;

  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_next;
  logic [SW-1:0]      clear_idx;
  logic [SW-1:0]      clear_idx_next;
  logic [CNT_W-1:0]   cur_distinct;
  logic [CNT_W-1:0]   cur_distinct_next;
  logic [CNT_W-1:0]   best_distinct;
  logic [CNT_W-1:0]   best_distinct_next;
  logic [CNT_W-1:0]   old_cnt_next;
  logic [CNT_W-1:0]   old_cnt_hold;

  logic               rd_en;
  logic               mem_we;
  logic [SW-1:0]      mem_waddr;
  wdcm_cnt_entry_t    mem_wdata;
  logic               out_load;
  logic               out_take;
  logic [CNT_W-1:0]   res_min;
  logic               res_short;

  // Arithmetic of one update.
  logic [CNT_W-1:0]   cs;
  logic [CNT_W-1:0]   co;
  logic [CNT_W-1:0]   cs_inc;
  logic [CNT_W-1:0]   dist1;
  logic [CNT_W-1:0]   co_eff;
  logic [CNT_W-1:0]   co_dec;
  logic [CNT_W-1:0]   dist2;
  logic [CNT_W-1:0]   best_upd;
  logic               same_sym;

  assign head_sym   = q_head[SW-1:0];
  assign head_old   = q_head[2*SW-1:SW];
  assign head_flags = wdcm_flags_t'(q_head[2*SW +: FLAGS_W]);
  assign clearing   = (state == B_CLEAR);
  assign out_take   = out_valid && !out_stall;

  // New counts, distinct count and minimum for the item under update.
  always_comb begin
    cs       = (rd_a.tag == epoch) ? rd_a.cnt : '0;
    co       = (rd_b.tag == epoch) ? rd_b.cnt : '0;
    same_sym = (e_sym == e_old);
    cs_inc   = cs + 1'b1;
    dist1    = cur_distinct + CNT_W'(cs == '0);
    co_eff   = same_sym ? cs_inc : co;
    co_dec   = co_eff;
    dist2    = dist1;
    if (co_eff != '0) begin
      co_dec = co_eff - 1'b1;
      if ((co_dec == '0) && (dist1 != '0)) begin
        dist2 = dist1 - 1'b1;
      end
    end
    if (e_flags.has_old) begin
      best_upd = (dist2 < best_distinct) ? dist2 : best_distinct;
    end else if (e_flags.first_full) begin
      best_upd = dist1;
    end else begin
      best_upd = best_distinct;
    end
    if (e_flags.has_old || e_flags.first_full) begin
      res_min   = best_upd;
      res_short = 1'b0;
    end else begin
      res_min   = dist1;
      res_short = 1'b1;
    end
  end

  // Sequencer: clearing pass, read, update, write of the departing count.
  always_comb begin
    state_next         = state;
    epoch_next         = epoch;
    clear_idx_next     = clear_idx;
    cur_distinct_next  = cur_distinct;
    best_distinct_next = best_distinct;
    old_cnt_next       = old_cnt_hold;
    q_pop              = 1'b0;
    rd_en              = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = e_sym;
    mem_wdata          = '{tag: epoch, cnt: cs_inc};
    out_load           = 1'b0;
    unique case (state)
      B_CLEAR: begin
        mem_we         = 1'b1;
        mem_waddr      = clear_idx;
        mem_wdata      = '0;
        clear_idx_next = clear_idx + 1'b1;
        if (clear_idx == '1) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = B_CALC;
        end
      end
      B_CALC: begin
        if (e_flags.last) begin
          // End of sequence: deliver and retire the count table by tag.
          if (!out_valid || out_take) begin
            out_load           = 1'b1;
            cur_distinct_next  = '0;
            best_distinct_next = '0;
            epoch_next         = epoch + 1'b1;
            if (epoch == '1) begin
              clear_idx_next = '0;
              state_next     = B_CLEAR;
            end else begin
              state_next = B_IDLE;
            end
          end
        end else begin
          mem_we             = 1'b1;
          mem_waddr          = e_sym;
          mem_wdata.cnt      = (e_flags.has_old && same_sym) ? co_dec : cs_inc;
          cur_distinct_next  = e_flags.has_old ? dist2 : dist1;
          best_distinct_next = best_upd;
          old_cnt_next       = co_dec;
          if (e_flags.has_old && !same_sym && (co_eff != '0)) begin
            state_next = B_WRITE_OLD;
          end else begin
            state_next = B_IDLE;
          end
        end
      end
      B_WRITE_OLD: begin
        mem_we        = 1'b1;
        mem_waddr     = e_old;
        mem_wdata.cnt = old_cnt_hold;
        state_next    = B_IDLE;
      end
      default: begin
        state_next = B_CLEAR;
      end
    endcase
    // A register write abandons the sequence and retires its tag.
    if (clr) begin
      cur_distinct_next  = '0;
      best_distinct_next = '0;
      epoch_next         = epoch + 1'b1;
      if (epoch == '1) begin
        clear_idx_next = '0;
        state_next     = B_CLEAR;
      end else if (state != B_CLEAR) begin
        state_next = B_IDLE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_CLEAR;
      epoch         <= '0;
      clear_idx     <= '0;
      cur_distinct  <= '0;
      best_distinct <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      epoch         <= epoch_next;
      clear_idx     <= clear_idx_next;
      cur_distinct  <= cur_distinct_next;
      best_distinct <= best_distinct_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    old_cnt_hold <= old_cnt_next;
    if (q_pop) begin
      e_sym   <= head_sym;
      e_old   <= head_old;
      e_flags <= head_flags;
    end
    if (out_load) begin
      min_distinct   <= res_min;
      short_sequence <= res_short;
    end
  end

  // Count table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= cnt_mem[head_sym];
      rd_b <= cnt_mem[head_old];
    end
  end

  // No item is taken while the clearing pass runs.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !q_pop)
    else $error("item taken during the clearing pass");

  // The departing count is written only right after an update.
  a_write_old_order: assert property (@(posedge clk) disable iff (rst)
    (state == B_WRITE_OLD) |-> ($past(state) == B_CALC))
    else $error("departing count written out of order");

  // A result appears only from an update of a last item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_CALC && $past(e_flags.last)))
    else $error("result raised outside a last item update");

endmodule
